// ===== design/lef_pkg.sv =====
// Package for the 3x3 Laplacian edge filter.
// Widths, register indexes, reset values and the stage payload types.
// No dependencies.
package lef_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int LINE_W     = 2 * PIX_W;
  localparam int MAG_W      = PIX_W + 3;
  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 8;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int GAIN_RESET   = 256;
  localparam int WIDTH_RESET  = 256;
  localparam int HEIGHT_RESET = 256;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [COL_W-1:0]  w_last;
    logic [ROW_W-1:0]  h_last;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [COL_W-1:0] col;
    logic             res;
    logic             last;
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
  } s1_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
    logic             last;
  } s2_t;

endpackage

// ===== design/lef_ifs.sv =====
// Channel interfaces of the Laplacian edge filter: pixel in, result out, config write.
// Depends on lef_pkg.
interface lef_pix_if;
  import lef_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;
  modport source(output valid, pixel, frame_start, input ready);
  modport sink(input valid, pixel, frame_start, output ready);
endinterface

interface lef_res_if;
  import lef_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_value;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             frame_last;
  modport source(output valid, edge_value, out_row, out_col, frame_last, input ready);
  modport sink(input valid, edge_value, out_row, out_col, frame_last, output ready);
endinterface

interface lef_cfg_if;
  import lef_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/lef_line_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds both line stores side by side. No dependencies.
module lef_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/lef_cfg_regs.sv =====
// Configuration registers: gain, and width/height clamped and kept as last index.
// Depends on lef_pkg and lef_cfg_if.
module lef_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  lef_cfg_if.sink       cfg_ch,
  output lef_pkg::cfg_t cfg
);
  import lef_pkg::*;

  logic [GAIN_W-1:0]  gain_r;
  logic [COL_W-1:0]   w_last_r, w_last_nxt;
  logic [ROW_W-1:0]   h_last_r, h_last_nxt;
  logic [IMG_W_W-1:0] wv;
  logic [IMG_H_W-1:0] hv;

  assign cfg_ch.ready = 1'b1;
  assign wv = cfg_ch.data[IMG_W_W-1:0];
  assign hv = cfg_ch.data[IMG_H_W-1:0];

  always_comb begin
    if (wv < IMG_W_W'(3)) begin
      w_last_nxt = COL_W'(2);
    end else if (int'(wv) > MAX_WIDTH) begin
      w_last_nxt = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last_nxt = COL_W'(wv - IMG_W_W'(1));
    end
    if (hv < IMG_H_W'(3)) begin
      h_last_nxt = ROW_W'(2);
    end else if (int'(hv) > MAX_HEIGHT) begin
      h_last_nxt = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last_nxt = ROW_W'(hv - IMG_H_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_W'(GAIN_RESET);
      w_last_r <= COL_W'(WIDTH_RESET - 1);
      h_last_r <= ROW_W'(HEIGHT_RESET - 1);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_GAIN:         gain_r   <= cfg_ch.data[GAIN_W-1:0];
        REG_IMAGE_WIDTH:  w_last_r <= w_last_nxt;
        REG_IMAGE_HEIGHT: h_last_r <= h_last_nxt;
        default: ;
      endcase
    end
  end

  assign cfg.gain   = gain_r;
  assign cfg.w_last = w_last_r;
  assign cfg.h_last = h_last_r;

endmodule

// ===== design/lef_window.sv =====
// 3x3 window stage: shifts columns in, forms |8*center - neighbors|, registers it.
// Produces the line RAM write-back. Depends on lef_pkg.
module lef_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s1_valid,
  input  lef_pkg::s1_t              s1,
  output logic                      s1_ready,
  input  logic [lef_pkg::LINE_W-1:0] rd_data,
  output logic                      we,
  output logic [lef_pkg::LINE_W-1:0] wdata,
  output logic                      s2_valid,
  output lef_pkg::s2_t              s2,
  input  logic                      s2_ready
);
  import lef_pkg::*;

  // columns col-2 and col-1, each top, middle, bottom
  logic [PIX_W-1:0]        win_r [6];
  logic [PIX_W-1:0]        top, mid;
  logic [MAG_W-1:0]        nb, ctr8, mag;
  logic signed [MAG_W:0]   diff;
  logic                    adv;
  logic                    s2_valid_r;
  s2_t                     s2_r;

  assign top = rd_data[LINE_W-1:PIX_W];
  assign mid = rd_data[PIX_W-1:0];

  assign s1_ready = !s2_valid_r || s2_ready;
  assign adv      = s1_valid && s1_ready;

  always_comb begin
    nb = MAG_W'(win_r[0]) + MAG_W'(win_r[1]) + MAG_W'(win_r[2]) + MAG_W'(win_r[3]) +
         MAG_W'(win_r[5]) + MAG_W'(top) + MAG_W'(mid) + MAG_W'(s1.px);
    ctr8 = {win_r[4], 3'b000};
    diff = $signed({1'b0, ctr8}) - $signed({1'b0, nb});
    mag  = diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (adv) begin
        s2_valid_r <= s1.res;
        win_r[0]   <= win_r[3];
        win_r[1]   <= win_r[4];
        win_r[2]   <= win_r[5];
        win_r[3]   <= top;
        win_r[4]   <= mid;
        win_r[5]   <= s1.px;
      end else if (s2_ready) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r.mag  <= mag;
      s2_r.orow <= s1.orow;
      s2_r.ocol <= s1.ocol;
      s2_r.last <= s1.last;
    end
  end

  assign we       = adv;
  assign wdata    = {mid, s1.px};
  assign s2_valid = s2_valid_r;
  assign s2       = s2_r;

endmodule

// ===== design/lef_scale.sv =====
// Gain stage: magnitude times Q8.8 gain, drop fraction, saturate to 8 bits.
// Holds the result output register. Depends on lef_pkg and lef_res_if.
module lef_scale (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      s2_valid,
  input  lef_pkg::s2_t              s2,
  output logic                      s2_ready,
  input  logic [lef_pkg::GAIN_W-1:0] gain,
  lef_res_if.source                 out_ch
);
  import lef_pkg::*;

  localparam int PROD_W = MAG_W + GAIN_W;

  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  sat;
  logic              out_valid_r;
  logic [PIX_W-1:0]  edge_r;
  logic [ROW_W-1:0]  row_r;
  logic [COL_W-1:0]  col_r;
  logic              last_r;

  assign prod = PROD_W'(s2.mag) * PROD_W'(gain);
  assign sat  = (|prod[PROD_W-1:GAIN_FRAC+PIX_W]) ? {PIX_W{1'b1}}
                                                  : prod[GAIN_FRAC+PIX_W-1:GAIN_FRAC];

  assign s2_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_valid && s2_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      edge_r <= sat;
      row_r  <= s2.orow;
      col_r  <= s2.ocol;
      last_r <= s2.last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.edge_value = edge_r;
  assign out_ch.out_row    = row_r;
  assign out_ch.out_col    = col_r;
  assign out_ch.frame_last = last_r;

endmodule

// ===== design/laplacian_edge_filter_3x3.sv =====
// 3x3 Laplacian edge filter, top level: raster counters, line RAM, window and gain stages.
// A result passes the request, window and output registers; back-pressure can stall it.
// One pixel per clock unless stalled, set by the single read and write port of the RAM.
// Reset: synchronous active-low rst_n clears counters, valids, window; config to defaults.
// Line RAM is not cleared; rows 0 and 1 may read unwritten entries but yield no result.
// Depends on lef_pkg, lef_ifs, lef_line_ram, lef_cfg_regs, lef_window, lef_scale.
module laplacian_edge_filter_3x3 (
  input  logic      clk,
  input  logic      rst_n,
  lef_pix_if.sink   in_ch,
  lef_res_if.source out_ch,
  lef_cfg_if.sink   cfg_ch
);
  import lef_pkg::*;

  cfg_t              cfg;
  logic [COL_W-1:0]  col_r, col_in;
  logic [ROW_W-1:0]  row_r, row_in;
  logic              accept;
  logic              s1_valid_r, s1_ready;
  s1_t               s1_r;
  logic              we;
  logic [LINE_W-1:0] wdata, ram_q, rd_data;
  logic              fwd_r;
  logic [LINE_W-1:0] fwd_data_r;
  logic              s2_valid, s2_ready;
  s2_t               s2;

  lef_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign in_ch.ready = !s1_valid_r || s1_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign col_in      = in_ch.frame_start ? '0 : col_r;
  assign row_in      = in_ch.frame_start ? '0 : row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
        fwd_r      <= we && (s1_r.col == col_in);
        if (col_in >= cfg.w_last) begin
          col_r <= '0;
          row_r <= (row_in >= cfg.h_last) ? '0 : row_in + 1'b1;
        end else begin
          col_r <= col_in + 1'b1;
          row_r <= row_in;
        end
      end else if (s1_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data_r <= wdata;
      s1_r.px    <= in_ch.pixel;
      s1_r.col   <= col_in;
      s1_r.res   <= (row_in >= ROW_W'(2)) && (col_in >= COL_W'(2)) &&
                    (row_in <= cfg.h_last) && (col_in <= cfg.w_last);
      s1_r.last  <= (row_in == cfg.h_last) && (col_in == cfg.w_last);
      s1_r.orow  <= row_in - 1'b1;
      s1_r.ocol  <= col_in - 1'b1;
    end
  end

  lef_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (LINE_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (s1_r.col),
    .wdata (wdata),
    .re    (accept),
    .raddr (col_in),
    .rdata (ram_q)
  );

  // write-back to the entry being read in the same cycle
  assign rd_data = fwd_r ? fwd_data_r : ram_q;

  lef_window u_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1       (s1_r),
    .s1_ready (s1_ready),
    .rd_data  (rd_data),
    .we       (we),
    .wdata    (wdata),
    .s2_valid (s2_valid),
    .s2       (s2),
    .s2_ready (s2_ready)
  );

  lef_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2       (s2),
    .s2_ready (s2_ready),
    .gain     (cfg.gain),
    .out_ch   (out_ch)
  );

  a_we_needs_s1 : assert property (@(posedge clk) disable iff (!rst_n)
    we |-> s1_valid_r)
    else $error("line RAM write without a request in the window stage");

  a_s1_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_ready) |=> (s1_valid_r && $stable(s1_r.col) && $stable(s1_r.px)))
    else $error("stalled window-stage request changed");

  a_fwd_same_addr : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && we && (s1_r.col == col_in)) |=> fwd_r)
    else $error("read of entry written in the same cycle not forwarded");

  a_col_in_store : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (int'(col_r) < MAX_WIDTH))
    else $error("column count beyond line store");

endmodule
